// ----- src/analog_stick_circle_clamp_top_macros.svh -----
// Assertion helpers shared by the clamp RTL.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ANALOG_STICK_CIRCLE_CLAMP_TOP_MACROS_SVH
`define ANALOG_STICK_CIRCLE_CLAMP_TOP_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold.
`define ASC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- src/asc_pkg.sv -----
`default_nettype none

package asc_pkg;

  // magnitude bits of a clamped axis (radius is at most 127)
  localparam int unsigned QBITS = 7;
  // dead zone, square/product, target, one stage per q bit, scale
  localparam int unsigned STICK_LAT = 3 + QBITS + 1;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE       = 3'd0,
    REG_MAIN_RADIUS     = 3'd1,
    REG_SUB_RADIUS      = 3'd2,
    REG_TRIGGER_FLOOR   = 3'd3,
    REG_TRIGGER_CEILING = 3'd4
  } asc_reg_e;

  localparam logic [6:0] DEAD_ZONE_RST       = 7'd15;
  localparam logic [6:0] MAIN_RADIUS_RST     = 7'd56;
  localparam logic [6:0] SUB_RADIUS_RST      = 7'd44;
  localparam logic [7:0] TRIGGER_FLOOR_RST   = 8'd30;
  localparam logic [7:0] TRIGGER_CEILING_RST = 8'd180;

  // one axis in flight through the bit-serial radial search
  typedef struct packed {
    logic [27:0]      t;    // (a*r)^2
    logic [31:0]      p;    // q*q*sq
    logic [31:0]      qs;   // q*sq
    logic [QBITS-1:0] q;
    logic [7:0]       a;    // |axis| after dead zone
    logic             neg;
  } asc_lane_t;

  // side payload carried alongside the stick pipeline
  typedef struct packed {
    logic       err;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] sub_x;
    logic [7:0] sub_y;
    logic [7:0] trig_l_raw;
    logic [7:0] trig_r_raw;
    logic [7:0] trig_l;
    logic [7:0] trig_r;
  } asc_side_t;

endpackage

`default_nettype wire

// ----- src/analog_stick_circle_clamp_top.sv -----
// Analog stick conditioner: dead zone, radial clamp to a circle, 3/2 gain with
// saturation, and trigger floor/ceiling. Issue a request by raising start; busy
// stays low, so one request is taken every clock. Each result is marked by a
// one-cycle out_valid strobe, and the receiver cannot stall it: latch the
// outputs on the strobe. Throughput is one request per cycle; the radial
// search settles one bit of each clamped axis per pipeline stage (seven
// stages) behind the dead zone, product and target stages. Write the
// configuration registers only while no request is in flight.
`default_nettype none
`include "analog_stick_circle_clamp_top_macros.svh"

module analog_stick_circle_clamp_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_pad_error,
  input  wire logic signed [7:0] in_stick_x,
  input  wire logic signed [7:0] in_stick_y,
  input  wire logic signed [7:0] in_sub_x,
  input  wire logic signed [7:0] in_sub_y,
  input  wire logic        [7:0] in_trigger_left,
  input  wire logic        [7:0] in_trigger_right,
  // result channel
  output      logic              out_valid,
  output      logic              out_error,
  output      logic signed [7:0] out_stick_x,
  output      logic signed [7:0] out_stick_y,
  output      logic signed [7:0] out_sub_x,
  output      logic signed [7:0] out_sub_y,
  output      logic        [7:0] out_trigger_left,
  output      logic        [7:0] out_trigger_right,
  // configuration write channel
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic        [2:0] cfg_index,
  input  wire logic        [7:0] cfg_data
);

  localparam int unsigned LAT = asc_pkg::STICK_LAT;

  logic [6:0] dead_zone_r, main_radius_r, sub_radius_r;
  logic [7:0] trigger_floor_r, trigger_ceiling_r;

  // Accept every request; configuration writes always complete.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_acc;
  assign in_acc = start && !busy;

  // Update one register per write; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r       <= asc_pkg::DEAD_ZONE_RST;
      main_radius_r     <= asc_pkg::MAIN_RADIUS_RST;
      sub_radius_r      <= asc_pkg::SUB_RADIUS_RST;
      trigger_floor_r   <= asc_pkg::TRIGGER_FLOOR_RST;
      trigger_ceiling_r <= asc_pkg::TRIGGER_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asc_pkg::REG_DEAD_ZONE:       dead_zone_r       <= cfg_data[6:0];
        asc_pkg::REG_MAIN_RADIUS:     main_radius_r     <= cfg_data[6:0];
        asc_pkg::REG_SUB_RADIUS:      sub_radius_r      <= cfg_data[6:0];
        asc_pkg::REG_TRIGGER_FLOOR:   trigger_floor_r   <= cfg_data;
        asc_pkg::REG_TRIGGER_CEILING: trigger_ceiling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero at or below the floor; otherwise cap at the ceiling, then subtract
  // the floor with 8-bit wrap.
  function automatic logic [7:0] trig(logic [7:0] t, logic [7:0] fl, logic [7:0] cl);
    logic [7:0] c;
    c = (t > cl) ? cl : t;
    return (t <= fl) ? 8'd0 : 8'(c - fl);
  endfunction

  // Triggers and raw sample ride a delay line that matches the stick pipeline.
  asc_pkg::asc_side_t side_in;
  asc_pkg::asc_side_t side_r [LAT];

  always_comb begin
    side_in.err        = in_pad_error;
    side_in.stick_x    = in_stick_x;
    side_in.stick_y    = in_stick_y;
    side_in.sub_x      = in_sub_x;
    side_in.sub_y      = in_sub_y;
    side_in.trig_l_raw = in_trigger_left;
    side_in.trig_r_raw = in_trigger_right;
    side_in.trig_l     = trig(in_trigger_left, trigger_floor_r, trigger_ceiling_r);
    side_in.trig_r     = trig(in_trigger_right, trigger_floor_r, trigger_ceiling_r);
  end

  // Advance every cycle: nothing downstream can hold results off.
  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int unsigned i = 1; i < LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  logic              main_vld, sub_vld;
  logic signed [7:0] main_x, main_y, sub_x_c, sub_y_c;

  asc_stick u_main (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_acc),
    .in_x      (in_stick_x),
    .in_y      (in_stick_y),
    .dead_zone (dead_zone_r),
    .radius    (main_radius_r),
    .out_vld   (main_vld),
    .out_x     (main_x),
    .out_y     (main_y)
  );

  asc_stick u_sub (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_acc),
    .in_x      (in_sub_x),
    .in_y      (in_sub_y),
    .dead_zone (dead_zone_r),
    .radius    (sub_radius_r),
    .out_vld   (sub_vld),
    .out_x     (sub_x_c),
    .out_y     (sub_y_c)
  );

  // An error sample passes through untouched.
  asc_pkg::asc_side_t side_o;
  assign side_o = side_r[LAT-1];

  assign out_valid         = main_vld;
  assign out_error         = side_o.err;
  assign out_stick_x       = side_o.err ? side_o.stick_x    : main_x;
  assign out_stick_y       = side_o.err ? side_o.stick_y    : main_y;
  assign out_sub_x         = side_o.err ? side_o.sub_x      : sub_x_c;
  assign out_sub_y         = side_o.err ? side_o.sub_y      : sub_y_c;
  assign out_trigger_left  = side_o.err ? side_o.trig_l_raw : side_o.trig_l;
  assign out_trigger_right = side_o.err ? side_o.trig_r_raw : side_o.trig_r;

  `ASC_ASSERT_NEVER(a_stick_lockstep, main_vld != sub_vld, "stick pipelines out of step")
  `ASC_ASSERT_NEVER(a_never_busy, busy, "request channel stalled")
  `ASC_ASSERT_IMPL(a_err_passthru, out_valid && out_error, out_trigger_left == side_o.trig_l_raw, "error sample altered")

endmodule

`default_nettype wire

// ----- src/asc_stick.sv -----
`default_nettype none
`include "analog_stick_circle_clamp_top_macros.svh"

module asc_stick (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic signed [7:0] in_x,
  input  wire logic signed [7:0] in_y,
  input  wire logic        [6:0] dead_zone,
  input  wire logic        [6:0] radius,
  output      logic              out_vld,
  output      logic signed [7:0] out_x,
  output      logic signed [7:0] out_y
);

  localparam int unsigned QB = asc_pkg::QBITS;
  localparam int unsigned LAT = asc_pkg::STICK_LAT;

  function automatic logic signed [8:0] dz_apply(logic signed [7:0] v, logic [6:0] d);
    logic signed [8:0] vs;
    logic signed [8:0] ds;
    vs = {v[7], v};
    ds = {2'b00, d};
    if (vs < ds && vs > -ds) begin
      return 9'sd0;
    end else if (vs > 9'sd0) begin
      return vs - ds;
    end else begin
      return vs + ds;
    end
  endfunction

  // try the next q bit: (q+2^b)^2*sq = p + 2*2^b*q*sq + 4^b*sq
  function automatic asc_pkg::asc_lane_t step(asc_pkg::asc_lane_t l, logic [15:0] sq,
                                               int unsigned b);
    logic [31:0] cand;
    asc_pkg::asc_lane_t o;
    o = l;
    cand = l.p + (l.qs << (b + 1)) + ({16'b0, sq} << (2 * b));
    if (cand <= {4'b0, l.t}) begin
      o.p = cand;
      o.qs = l.qs + ({16'b0, sq} << b);
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [7:0] scale(logic [7:0] mag, logic neg);
    logic [9:0] s;
    s = ({2'b00, mag} + {1'b0, mag, 1'b0}) >> 1;
    if (neg) begin
      return (s > 10'd128) ? 8'h80 : 8'((~s) + 10'd1);
    end else begin
      return (s > 10'd127) ? 8'h7f : s[7:0];
    end
  endfunction

  logic [LAT-1:0] vld_r;

  // stage 1: dead zone and magnitude
  logic [7:0] ax1_r, ay1_r;
  logic       sx1_r, sy1_r;
  // stage 2: radius square and products
  logic [7:0]  ax2_r, ay2_r;
  logic        sx2_r, sy2_r;
  logic [15:0] sq2_r;
  logic [13:0] arx2_r, ary2_r, rr2_r;
  // stage 3: targets and clamp decision
  asc_pkg::asc_lane_t lx3_r, ly3_r;
  logic [15:0] sq3_r;
  logic        over3_r;
  // search stages
  asc_pkg::asc_lane_t lx_r [QB];
  asc_pkg::asc_lane_t ly_r [QB];
  logic [15:0]        sq_r [QB];
  logic               over_r [QB];

  logic signed [8:0] dx, dy;

  always_comb begin
    dx = dz_apply(in_x, dead_zone);
    dy = dz_apply(in_y, dead_zone);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ax1_r <= dx[8] ? 8'(-dx) : dx[7:0];
    ay1_r <= dy[8] ? 8'(-dy) : dy[7:0];
    sx1_r <= dx[8];
    sy1_r <= dy[8];

    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    sq2_r  <= 16'(ax1_r * ax1_r) + 16'(ay1_r * ay1_r);
    arx2_r <= 14'(ax1_r * radius);
    ary2_r <= 14'(ay1_r * radius);
    rr2_r  <= 14'(radius * radius);

    lx3_r   <= '{t: 28'(arx2_r * arx2_r), p: '0, qs: '0, q: '0, a: ax2_r, neg: sx2_r};
    ly3_r   <= '{t: 28'(ary2_r * ary2_r), p: '0, qs: '0, q: '0, a: ay2_r, neg: sy2_r};
    sq3_r   <= sq2_r;
    over3_r <= sq2_r > {2'b00, rr2_r};
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    asc_pkg::asc_lane_t lx_src, ly_src;
    logic [15:0] sq_src;
    logic        over_src;
    if (s == 0) begin : g_first
      assign lx_src   = lx3_r;
      assign ly_src   = ly3_r;
      assign sq_src   = sq3_r;
      assign over_src = over3_r;
    end else begin : g_next
      assign lx_src   = lx_r[s-1];
      assign ly_src   = ly_r[s-1];
      assign sq_src   = sq_r[s-1];
      assign over_src = over_r[s-1];
    end
    always_ff @(posedge clk) begin
      lx_r[s]   <= step(lx_src, sq_src, QB - 1 - s);
      ly_r[s]   <= step(ly_src, sq_src, QB - 1 - s);
      sq_r[s]   <= sq_src;
      over_r[s] <= over_src;
    end
  end

  logic [7:0] mag_x, mag_y;
  logic signed [7:0] out_x_r, out_y_r;

  always_comb begin
    mag_x = over_r[QB-1] ? {1'b0, lx_r[QB-1].q} : lx_r[QB-1].a;
    mag_y = over_r[QB-1] ? {1'b0, ly_r[QB-1].q} : ly_r[QB-1].a;
  end

  always_ff @(posedge clk) begin
    out_x_r <= scale(mag_x, lx_r[QB-1].neg);
    out_y_r <= scale(mag_y, ly_r[QB-1].neg);
  end

  assign out_vld = vld_r[LAT-1];
  assign out_x   = out_x_r;
  assign out_y   = out_y_r;

  `ASC_ASSERT_IMPL(a_over_nonzero, vld_r[2] && over3_r, sq3_r != 16'd0, "clamp on zero vector")
  `ASC_ASSERT_IMPL(a_search_bound, vld_r[LAT-2], lx_r[QB-1].p <= {4'b0, lx_r[QB-1].t}, "search overshot target")
  `ASC_ASSERT_IMPL(a_clamp_shrinks, vld_r[LAT-2] && over_r[QB-1], lx_r[QB-1].a == 8'd0 || {1'b0, lx_r[QB-1].q} < lx_r[QB-1].a, "clamp grew axis")

endmodule

`default_nettype wire
